// ===== hdl/rme_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the rotation matrix to Euler angle unit.
// Depends on nothing; every other file of the block imports it.
package rme_pkg;

    localparam int DATA_W          = 16;
    localparam int OPND_W          = 17;
    localparam int SUM_W           = 32;
    localparam int REM_W           = 17;
    localparam int SQRT_STEPS      = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int PRE_SHIFT       = 16;
    localparam int CORD_W          = 38;
    localparam int ANG_W           = 35;
    localparam int THR_W           = 15;
    localparam int ADDR_W          = 3;
    localparam int PDATA_W         = 32;
    localparam int ANGLE_FRAC_DEF  = 13;
    localparam logic [THR_W-1:0] THR_RESET = 15'd1;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] r00;
        logic signed [DATA_W-1:0] r10;
        logic signed [DATA_W-1:0] r20;
        logic signed [DATA_W-1:0] r21;
        logic signed [DATA_W-1:0] r22;
        logic signed [DATA_W-1:0] r11;
        logic signed [DATA_W-1:0] r12;
    } side_t;

    typedef struct packed {
        logic [SUM_W-1:0]  n;
        logic [REM_W-1:0]  rem;
        logic [DATA_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } cordic_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0: a = 35'sd843314857;
            1: a = 35'sd497837829;
            2: a = 35'sd263043837;
            3: a = 35'sd133525159;
            4: a = 35'sd67021687;
            5: a = 35'sd33543516;
            6: a = 35'sd16775851;
            7: a = 35'sd8388437;
            8: a = 35'sd4194283;
            9: a = 35'sd2097149;
            default: a = ANG_W'(64'sd1073741824 >>> idx);
        endcase
        return a;
    endfunction

    // Folds the left half plane onto the right one and scales up the operands.
    function automatic cordic_t cordic_init(input logic signed [OPND_W-1:0] y,
                                            input logic signed [OPND_W-1:0] x);
        cordic_t c;
        logic signed [CORD_W-1:0] xe;
        logic signed [CORD_W-1:0] ye;
        xe = CORD_W'(x);
        ye = CORD_W'(y);
        c.z = '0;
        if (x < 0)
        begin
            c.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            xe = -xe;
            ye = -ye;
        end
        c.x = xe <<< PRE_SHIFT;
        c.y = ye <<< PRE_SHIFT;
        return c;
    endfunction

endpackage

// ===== hdl/rotation_matrix_to_euler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the rotation matrix to Euler angle unit.
// Depends on rme_pkg, rme_sqrt_cell and rme_cordic_cell.
//
// The unit takes one matrix word per cycle while in_ready is high and returns one angle word
// per matrix, in order. Each word passes through one squaring stage, one add stage,
// sixteen square root cells, one stage that compares against the threshold and picks the
// operands, and three parallel rows of 24 CORDIC cells whose results are rounded into the
// output register. Every stage holds its word until the next one is free, so empty stages
// close up while the output is stalled.
module rotation_matrix_to_euler_unit #(
    parameter int ANGLE_FRAC_BITS = rme_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]        paddr,
    input  logic [rme_pkg::PDATA_W-1:0]       pwdata,
    output logic [rme_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [rme_pkg::DATA_W-1:0] r_00,
    input  logic signed [rme_pkg::DATA_W-1:0] r_10,
    input  logic signed [rme_pkg::DATA_W-1:0] r_20,
    input  logic signed [rme_pkg::DATA_W-1:0] r_21,
    input  logic signed [rme_pkg::DATA_W-1:0] r_22,
    input  logic signed [rme_pkg::DATA_W-1:0] r_11,
    input  logic signed [rme_pkg::DATA_W-1:0] r_12,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rme_pkg::DATA_W-1:0] angle_x,
    output logic signed [rme_pkg::DATA_W-1:0] angle_y,
    output logic signed [rme_pkg::DATA_W-1:0] angle_z,
    output logic                              is_singular
);
    import rme_pkg::*;

    localparam int NSTAGE   = 3 + SQRT_STEPS + CORDIC_STEPS;
    localparam int ST_PREP  = 2 + SQRT_STEPS;
    localparam int NSIDE    = ST_PREP;
    localparam int RND_SH   = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W:0] RND_HALF = (ANG_W+1)'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [ANG_W:0] SAT_HI = 36'sd32767;
    localparam logic signed [ANG_W:0] SAT_LO = -36'sd32768;

    logic [THR_W-1:0]       thr_reg;
    logic                   cfg_wr;
    logic [NSTAGE-1:0]      vld_reg;
    logic [NSTAGE:0]        en;
    logic                   out_valid_reg;
    side_t                  side_reg [NSIDE];
    side_t                  side_in;
    logic [SUM_W-2:0]       sq0_reg;
    logic [SUM_W-2:0]       sq1_reg;
    logic [SUM_W-1:0]       sum_reg;
    sqrt_t                  sqrt_d [SQRT_STEPS+1];
    logic                   sing_reg [CORDIC_STEPS+1];
    cordic_t                cx [CORDIC_STEPS+1];
    cordic_t                cy [CORDIC_STEPS+1];
    cordic_t                cz [CORDIC_STEPS+1];
    logic [DATA_W-1:0]      sy;
    logic                   sing_next;
    side_t                  sp;
    logic signed [OPND_W-1:0] ya;
    logic signed [OPND_W-1:0] xa;
    logic signed [DATA_W-1:0] angle_x_reg;
    logic signed [DATA_W-1:0] angle_y_reg;
    logic signed [DATA_W-1:0] angle_z_reg;
    logic                     is_singular_reg;

    function automatic logic signed [DATA_W-1:0] round_angle(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W:0] t;
        logic signed [ANG_W:0] r;
        t = (ANG_W+1)'(z) + RND_HALF;
        r = t >>> RND_SH;
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return DATA_W'(r);
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_THRESHOLD);
    assign prdata = (paddr[ADDR_W-1] == REG_THRESHOLD) ? PDATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    always_comb
    begin
        en[NSTAGE] = !out_valid_reg || out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en[NSTAGE])
            begin
                out_valid_reg <= vld_reg[NSTAGE-1];
            end
        end
    end

    assign side_in = '{r00: r_00, r10: r_10, r20: r_20, r21: r_21,
                       r22: r_22, r11: r_11, r12: r_12};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
            sq0_reg     <= (SUM_W-1)'(SUM_W'(r_00) * SUM_W'(r_00));
            sq1_reg     <= (SUM_W-1)'(SUM_W'(r_10) * SUM_W'(r_10));
        end
        if (en[1])
        begin
            side_reg[1] <= side_reg[0];
            sum_reg     <= SUM_W'(sq0_reg) + SUM_W'(sq1_reg);
        end
        for (int k = 2; k < NSIDE; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign sqrt_d[0] = '{n: sum_reg, rem: '0, root: '0};

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        rme_sqrt_cell u_cell (
            .clk (clk),
            .en  (en[2+g]),
            .d   (sqrt_d[g]),
            .q   (sqrt_d[g+1])
        );
    end

    assign sy = sqrt_d[SQRT_STEPS].root;
    assign sp = side_reg[NSIDE-1];
    assign sing_next = sy < {1'b0, thr_reg};

    always_comb
    begin
        if (sing_next)
        begin
            ya = OPND_W'(sp.r12);
            xa = OPND_W'(sp.r11);
        end
        else
        begin
            ya = -OPND_W'(sp.r21);
            xa = OPND_W'(sp.r22);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PREP])
        begin
            sing_reg[0] <= sing_next;
            cx[0] <= cordic_init(-OPND_W'(sp.r20), {1'b0, sy});
            cy[0] <= cordic_init(ya, xa);
            cz[0] <= cordic_init(OPND_W'(sp.r10), OPND_W'(sp.r00));
        end
        for (int k = 1; k <= CORDIC_STEPS; k++)
        begin
            if (en[ST_PREP+k])
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        rme_cordic_cell #(.STEP(g)) u_x (
            .clk (clk), .en (en[ST_PREP+1+g]), .d (cx[g]), .q (cx[g+1])
        );
        rme_cordic_cell #(.STEP(g)) u_y (
            .clk (clk), .en (en[ST_PREP+1+g]), .d (cy[g]), .q (cy[g+1])
        );
        rme_cordic_cell #(.STEP(g)) u_z (
            .clk (clk), .en (en[ST_PREP+1+g]), .d (cz[g]), .q (cz[g+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE])
        begin
            angle_x_reg     <= round_angle(cx[CORDIC_STEPS].z);
            angle_y_reg     <= round_angle(cy[CORDIC_STEPS].z);
            angle_z_reg     <= sing_reg[CORDIC_STEPS] ? '0 : round_angle(cz[CORDIC_STEPS].z);
            is_singular_reg <= sing_reg[CORDIC_STEPS];
        end
    end

    assign out_valid   = out_valid_reg;
    assign angle_x     = angle_x_reg;
    assign angle_y     = angle_y_reg;
    assign angle_z     = angle_z_reg;
    assign is_singular = is_singular_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_singular |-> angle_z == '0)
        else $error("Singular word carries a nonzero z angle.");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && (&vld_reg))
        else $error("Input held off while the chain has a free stage.");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("Accepted word did not enter the first stage.");

endmodule

// ===== hdl/rme_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One digit of the restoring square root chain: two radicand bits in, one root bit out.
// Depends on rme_pkg.
module rme_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  rme_pkg::sqrt_t d,
    output rme_pkg::sqrt_t q
);
    import rme_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;
    sqrt_t            q_next;

    always_comb
    begin
        rem_sh = {d.rem, d.n[SUM_W-1 -: 2]};
        trial  = {1'b0, d.root, 2'b01};
        take   = rem_sh >= trial;
        q_next.n    = d.n << 2;
        q_next.rem  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        q_next.root = {d.root[DATA_W-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= q_next;
        end
    end
endmodule

// ===== hdl/rme_cordic_cell.sv =====
`timescale 1ns / 1ps
// One vectoring rotation of the atan2 chain, with its arctangent constant built in.
// Depends on rme_pkg.
module rme_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  rme_pkg::cordic_t d,
    output rme_pkg::cordic_t q
);
    import rme_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    cordic_t                  q_next;

    always_comb
    begin
        xs = d.x >>> STEP;
        ys = d.y >>> STEP;
        q_next = d;
        if (d.y > 0)
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + ATAN;
        end
        else if (d.y < 0)
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= q_next;
        end
    end
endmodule

// ===== sim/rotation_matrix_to_euler_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the rotation matrix to Euler angle unit.
// Depends on rme_pkg and rotation_matrix_to_euler_unit; predicts every angle word in place.
module rotation_matrix_to_euler_unit_tb;
    import rme_pkg::*;

    localparam int N_RANDOM   = 1850;
    localparam int LATENCY    = 44;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] m[7];
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               sing;
    } angles_t;

    typedef struct {
        logic signed [15:0] m[7];
        logic               known;
        angles_t            want;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] r_00, r_10, r_20, r_21, r_22, r_11, r_12;
    logic signed [15:0] angle_x, angle_y, angle_z;
    logic is_singular;

    rotation_matrix_to_euler_unit dut (.*);

    angles_t pending_angles[$];
    logic [14:0] threshold;
    int errors;
    int cycles;
    int hold_cycles;
    bit sent_all;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -64'sd1 - ((-64'sd1 - v) >>> s);
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z, xs, ys;
        longint steps[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 24; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += steps[i];
            end
            else if (y < 0)
            begin
                x -= ys;
                y += xs;
                z -= steps[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] round_angle(longint z);
        longint r;
        r = floor_shift(z + (64'sd1 <<< 16), 17);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic angles_t euler_from_matrix(matrix_t a, logic [14:0] thr);
        angles_t e;
        longint sum, root, bitv;
        longint r00, r10;
        r00 = a.m[0];
        r10 = a.m[1];
        sum = r00 * r00 + r10 * r10;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > sum)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (sum >= root + bitv)
            begin
                sum -= root + bitv;
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        e.sing = root < thr;
        e.ax = round_angle(cordic_angle(-longint'(a.m[2]), root));
        if (!e.sing)
        begin
            e.ay = round_angle(cordic_angle(-longint'(a.m[3]), a.m[4]));
            e.az = round_angle(cordic_angle(a.m[1], a.m[0]));
        end
        else
        begin
            e.ay = round_angle(cordic_angle(a.m[6], a.m[5]));
            e.az = '0;
        end
        return e;
    endfunction

    task automatic write_threshold(logic [14:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_W'(4 * REG_THRESHOLD);
        pwdata = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        threshold = value;
    endtask

    task automatic wait_drained();
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_matrix(matrix_t a, bit known, angles_t want, bit gaps);
        angles_t e;
        if (gaps && $urandom_range(0, 2) == 0)
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
                @(negedge clk);
        {r_00, r_10, r_20, r_21, r_22, r_11, r_12} =
            {a.m[0], a.m[1], a.m[2], a.m[3], a.m[4], a.m[5], a.m[6]};
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = euler_from_matrix(a, threshold);
        if (known && e != want)
        begin
            $error("table row disagrees with the prediction");
            errors++;
        end
        pending_angles = {pending_angles, (known ? want : e)};
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_element(int kind);
        case (kind)
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'sh8000;
            4: return 16'sh7fff;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t a;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 7; k++)
            a.m[k] = (mode == 0) ? pick_element($urandom_range(0, 5)) :
                     (mode == 1) ? 16'($urandom) : pick_element(5);
        if (mode == 2)
        begin
            a.m[0] = 16'($urandom_range(0, 60) - 30);
            a.m[1] = 16'($urandom_range(0, 60) - 30);
        end
        return a;
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("angle word with no matrix outstanding");
                errors++;
            end
            else
            begin
                angles_t e;
                e = pending_angles.pop_front();
                if (angle_x !== e.ax)
                begin
                    $error("angle_x expected %0d actual %0d", e.ax, angle_x);
                    errors++;
                end
                if (angle_y !== e.ay)
                begin
                    $error("angle_y expected %0d actual %0d", e.ay, angle_y);
                    errors++;
                end
                if (angle_z !== e.az)
                begin
                    $error("angle_z expected %0d actual %0d", e.az, angle_z);
                    errors++;
                end
                if (is_singular !== e.sing)
                begin
                    $error("is_singular expected %0d actual %0d", e.sing, is_singular);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else if (!sent_all && $urandom_range(0, 3) == 0)
                out_ready = 1'b0;
            else
                out_ready = 1'b1;
        end
    end

    row_t stim_table[$];
    angles_t blank;
    matrix_t a;

    task automatic add_row(logic signed [15:0] m0, m1, m2, m3, m4, m5, m6,
                           bit known, logic signed [15:0] ax, ay, az, logic sing);
        row_t r;
        r.m = '{m0, m1, m2, m3, m4, m5, m6};
        r.known = known;
        r.want = '{ax, ay, az, sing};
        stim_table = {stim_table, r};
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        sent_all = 0;
        threshold = THR_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        {r_00, r_10, r_20, r_21, r_22, r_11, r_12} = '0;
        blank = '{16'sd0, 16'sd0, 16'sd0, 1'b0};

        add_row(16384, 0, 0, 0, 16384, 16384, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(0, 0, -16384, 0, 16384, 16384, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 16384, 0, 0, 16384, -16384, 0, 0, 0, 0, 0);
        add_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(-16384, -1, 0, -1, -16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 0, 0, 0, 0, 0);
        add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 0, 0, 0, 0, 0);
        add_row(0, 16384, 0, 16384, 0, -16384, 16384, 0, 0, 0, 0, 0);
        add_row(11585, 11585, -8192, 8192, 14189, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0);
        add_row(0, -1, 0, 0, -1, -1, -1, 0, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
        begin
            for (int k = 0; k < 7; k++)
                a.m[k] = stim_table[i].m[k];
            send_matrix(a, stim_table[i].known, stim_table[i].want, 0);
        end
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_threshold(15'd0);
                1: write_threshold(15'd16384);
                2: write_threshold(15'h7fff);
                3: write_threshold(15'd20);
                default: write_threshold(15'($urandom_range(0, 16384)));
            endcase
            a.m = '{0, 0, 5, 5, 5, 5, 5};
            send_matrix(a, 0, blank, 0);
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                if (phase == 1 && n == 50)
                begin
                    hold_cycles = 200;
                    while (hold_cycles > 0)
                    begin
                        send_matrix(random_matrix(), 0, blank, 0);
                        if (pending_angles.size() > 80)
                            break;
                    end
                end
                if (phase == 2 && n == 100)
                    wait_drained();
                send_matrix(random_matrix(), 0, blank, 1);
            end
            wait_drained();
        end
        sent_all = 1;
        wait_drained();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
